>>> rtl/core/itocr_pkg.sv
// shared types, constants and the curve table for the overcurrent relay
// used by itocr_divider, itocr_curve and inverse_time_overcurrent_relay_unit
// no dependencies
package itocr_pkg;

  localparam int CURVE_TABLE_ENTRIES = 256;
  localparam int SEGS_PER_OCTAVE     = CURVE_TABLE_ENTRIES / 8;
  localparam int SEG_BITS            = $clog2(SEGS_PER_OCTAVE);
  localparam int IDX_W               = $clog2(CURVE_TABLE_ENTRIES + 1);
  localparam logic [16:0] DELAY_CAP  = 17'd100000;
  localparam logic [23:0] RATIO_MAX  = 24'hFFFFFF;
  localparam logic [63:0] LN2_Q32    = 64'd2977044472;

  // relay modes
  localparam logic [1:0] MODE_SETTLING = 2'd0;
  localparam logic [1:0] MODE_ARMED    = 2'd1;
  localparam logic [1:0] MODE_PICKUP   = 2'd2;
  localparam logic [1:0] MODE_TRIPPED  = 2'd3;

  // input kinds
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_REARM  = 1'b1;

  // configuration register indexes
  localparam logic [1:0] REG_PICKUP_LIMIT = 2'd0;
  localparam logic [1:0] REG_TIME_MULT    = 2'd1;
  localparam logic [1:0] REG_SETTLE_TIME  = 2'd2;

  typedef logic [31:0] curve_rom_t [0:CURVE_TABLE_ENTRIES];

  // control for the shared divider
  typedef struct packed {
    logic        start;
    logic [4:0]  steps;
    logic [63:0] dividend;
    logic [63:0] divisor;
  } div_req_t;

  // r^0.02 - 1 in Q0.32 at grid point i
  function automatic logic [31:0] grid_value(input int i);
    logic [63:0] oct;
    logic [63:0] s;
    logic [63:0] x;
    logic [63:0] frac;
    logic [63:0] l;
    logic [63:0] y;
    logic [63:0] z;
    logic [63:0] term;
    logic [63:0] sum;
    oct  = 64'(i / SEGS_PER_OCTAVE);
    s    = 64'(i % SEGS_PER_OCTAVE);
    x    = (64'd1 << 30) + ((s << 30) / SEGS_PER_OCTAVE);
    frac = '0;
    for (int b = 31; b >= 0; b--) begin
      x = (x * x) >> 30;
      if (x >= (64'd2 << 30)) begin
        x = x >> 1;
        frac = frac | (64'd1 << b);
      end
    end
    l    = (oct << 32) + frac;
    y    = l / 50;
    z    = (y * LN2_Q32) >> 32;
    term = z;
    sum  = z;
    for (int k = 2; k <= 7; k++) begin
      term = ((term * z) >> 32) / 64'(k);
      sum  = sum + term;
    end
    return sum[31:0];
  endfunction

  function automatic curve_rom_t build_rom();
    curve_rom_t rom;
    for (int i = 0; i <= CURVE_TABLE_ENTRIES; i++) begin
      rom[i] = grid_value(i);
    end
    return rom;
  endfunction

  localparam curve_rom_t CURVE_ROM = build_rom();

endpackage

>>> rtl/core/itocr_divider.sv
// shared restoring divider, one quotient bit per cycle
// depends on itocr_pkg
module itocr_divider
  import itocr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  div_req_t    req_i,
  output logic        done_o,
  output logic [23:0] quot_o
);

  logic [63:0] rem_q, rem_d;
  logic [63:0] dv_q, dv_d;
  logic [23:0] quot_q, quot_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;

  // one compare and subtract per step
  always_comb begin
    rem_d  = rem_q;
    dv_d   = dv_q;
    quot_d = quot_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      rem_d  = req_i.dividend;
      dv_d   = req_i.divisor;
      quot_d = '0;
      cnt_d  = req_i.steps;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (rem_q >= dv_q) begin
        rem_d  = rem_q - dv_q;
        quot_d = {quot_q[22:0], 1'b1};
      end else begin
        quot_d = {quot_q[22:0], 1'b0};
      end
      dv_d  = dv_q >> 1;
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    dv_q   <= dv_d;
    quot_q <= quot_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

>>> rtl/core/itocr_curve.sv
// curve lookup with linear interpolation: product registered, then the sum
// depends on itocr_pkg
module itocr_curve
  import itocr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [23:0] ratio_i,
  output logic        done_o,
  output logic [32:0] e_o
);

  logic [2:0]          oct;
  logic [39:0]         rn;
  logic [31:0]         f;
  logic [SEG_BITS-1:0] seg;
  logic [31:0]         fr;
  logic [IDX_W-1:0]    idx;
  logic [31:0]         pa, pb, diff;
  logic [31:0]         base_q;
  logic [63:0]         prod_q;
  logic                s1_q, s2_q;

  // octave from the leading one, then segment and fraction
  always_comb begin
    oct = 3'd7;
    if (!ratio_i[23]) begin
      oct = 3'd0;
      for (int b = 17; b <= 22; b++) begin
        if (ratio_i[b]) oct = 3'(b - 16);
      end
    end
    rn   = {ratio_i, 16'd0} >> oct;
    f    = rn[31:0];
    seg  = f[31 -: SEG_BITS];
    fr   = f << SEG_BITS;
    idx  = IDX_W'({oct, seg});
    pa   = CURVE_ROM[idx];
    pb   = CURVE_ROM[idx + IDX_W'(1)];
    diff = pb - pa;
  end

  always_ff @(posedge clk_i) begin
    base_q <= pa;
    prod_q <= 64'(diff) * 64'(fr);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= 1'b0;
      s2_q <= 1'b0;
    end else begin
      s1_q <= start_i;
      s2_q <= s1_q;
    end
  end

  // final add of base and scaled step
  always_ff @(posedge clk_i) begin
    e_o <= 33'(base_q) + 33'(prod_q[63:32]);
  end

  assign done_o = s2_q;

endmodule

>>> rtl/core/inverse_time_overcurrent_relay_unit.sv
// top level of the inverse-time overcurrent relay: sequencer and state
// depends on itocr_pkg, itocr_divider, itocr_curve
//
// channel  dir  handshake          payload
// s_axis   in   tvalid/tready      tuser kind, tdata sample + now_ms
// m_axis   out  tvalid/tready      tdata mode, event, drive, delay
// cfg      in   cfg_valid/ready    cfg_index_i, cfg_data_i
//
// a rearm or a sample that needs no curve goes straight to the result; a
// sample that needs the curve runs at most 24 steps of the shared divider
// for the ratio, the curve lookup, and at most 17 divider steps for the delay.
// reset returns to settling with drive enabled. one item at a time; a new
// item is taken while the last result waits in the output register.
module inverse_time_overcurrent_relay_unit
  import itocr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // current_sample[15:0], now_ms[47:16]
  input  logic        s_axis_tuser,   // kind[0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // mode[1:0], event_res[3:2],
                                      // drive_enable[4], trip_delay_ms[21:5]
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_EVAL  = 3'd1;
  localparam logic [2:0] ST_RDIV  = 3'd2;
  localparam logic [2:0] ST_CURVE = 3'd3;
  localparam logic [2:0] ST_CWAIT = 3'd4;
  localparam logic [2:0] ST_DDIV  = 3'd5;
  localparam logic [2:0] ST_FIN   = 3'd6;

  logic [2:0]  state_q, state_d;
  logic [15:0] limit_q, tms_q, settle_q;
  logic [1:0]  mode_q, mode_d;
  logic [31:0] ptime_q, ptime_d;
  logic [31:0] deadline_q, deadline_d;
  logic        tripped_q, tripped_d;
  logic [16:0] delay_q, delay_d;
  logic        kind_q;
  logic [15:0] sample_q;
  logic [31:0] now_q;
  logic [1:0]  m1_q, m1_d;
  logic        need_q, need_d;
  logic [23:0] ratio_q, ratio_d;
  logic        out_valid_q, out_valid_d;
  logic [23:0] out_data_q, out_data_d;

  div_req_t    div_req;
  logic        div_done;
  logic [23:0] div_quot;
  logic        curve_start;
  logic        curve_done;
  logic [32:0] curve_e;

  logic [1:0]  m1;
  logic [39:0] num;
  logic [41:0] den;
  logic [1:0]  fin_mode;
  logic [1:0]  fin_ev;
  logic        fin_trip;
  logic [31:0] fin_ptime;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign cfg_ready_o   = 1'b1;

  itocr_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  itocr_curve u_curve (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (curve_start),
    .ratio_i (ratio_q),
    .done_o  (curve_done),
    .e_o     (curve_e)
  );

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q  <= 16'd512;
      tms_q    <= 16'd4096;
      settle_q <= 16'd1000;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_PICKUP_LIMIT: limit_q  <= cfg_data_i;
        REG_TIME_MULT:    tms_q    <= cfg_data_i;
        REG_SETTLE_TIME:  settle_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // capture the input transaction
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      kind_q   <= s_axis_tuser;
      sample_q <= s_axis_tdata[15:0];
      now_q    <= s_axis_tdata[47:16];
    end
  end

  assign num = 40'(40'd14000000 * 40'(tms_q));
  assign den = 42'd297 * 42'(curve_e);

  // settling check ahead of the pickup logic
  always_comb begin
    m1 = mode_q;
    if (mode_q == MODE_SETTLING && now_q > deadline_q) m1 = MODE_ARMED;
  end

  // result of the item once the delay is settled
  always_comb begin
    fin_mode  = m1_q;
    fin_ev    = 2'd0;
    fin_ptime = ptime_q;
    fin_trip  = 1'b0;
    if (m1_q == MODE_ARMED && sample_q > limit_q) begin
      fin_ptime = now_q;
      fin_ev[0] = 1'b1;
      fin_mode  = MODE_PICKUP;
    end else if (m1_q == MODE_PICKUP && sample_q < limit_q) begin
      fin_mode = MODE_ARMED;
    end
    if (fin_mode == MODE_PICKUP && need_q &&
        now_q > fin_ptime + 32'(delay_q)) begin
      fin_trip  = 1'b1;
      fin_ev[1] = 1'b1;
      fin_mode  = MODE_TRIPPED;
    end
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    ptime_d     = ptime_q;
    deadline_d  = deadline_q;
    tripped_d   = tripped_q;
    delay_d     = delay_q;
    m1_d        = m1_q;
    need_d      = need_q;
    ratio_d     = ratio_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    div_req     = '0;
    curve_start = 1'b0;
    if (m_axis_tready) out_valid_d = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) state_d = ST_EVAL;
      end
      ST_EVAL: begin
        m1_d   = m1;
        need_d = (m1 == MODE_ARMED && sample_q > limit_q) ||
                 (m1 == MODE_PICKUP && sample_q >= limit_q);
        if (kind_q == KIND_REARM) begin
          m1_d       = MODE_SETTLING;
          need_d     = 1'b0;
          deadline_d = now_q + 32'(settle_q);
          state_d    = ST_FIN;
        end else if (!need_d) begin
          state_d = ST_FIN;
        end else if (limit_q == 16'd0 || 24'(sample_q) >= {limit_q, 8'd0}) begin
          ratio_d = RATIO_MAX;
          state_d = ST_CURVE;
        end else begin
          div_req.start    = 1'b1;
          div_req.steps    = 5'd24;
          div_req.dividend = {32'd0, sample_q, 16'd0};
          div_req.divisor  = 64'(limit_q) << 23;
          state_d          = ST_RDIV;
        end
      end
      ST_RDIV: begin
        if (div_done) begin
          ratio_d = div_quot;
          state_d = ST_CURVE;
        end
      end
      ST_CURVE: begin
        if (ratio_q <= 24'd65536) begin
          delay_d = DELAY_CAP;
          state_d = ST_FIN;
        end else begin
          curve_start = 1'b1;
          state_d     = ST_CWAIT;
        end
      end
      ST_CWAIT: begin
        if (curve_done) begin
          if (curve_e == 33'd0) begin
            delay_d = DELAY_CAP;
            state_d = ST_FIN;
          end else if ({4'd0, num, 20'd0} >= (64'(den) << 17)) begin
            delay_d = DELAY_CAP;
            state_d = ST_FIN;
          end else begin
            div_req.start    = 1'b1;
            div_req.steps    = 5'd17;
            div_req.dividend = {4'd0, num, 20'd0};
            div_req.divisor  = 64'(den) << 16;
            state_d          = ST_DDIV;
          end
        end
      end
      ST_DDIV: begin
        if (div_done) begin
          delay_d = (div_quot[16:0] < DELAY_CAP) ? div_quot[16:0] : DELAY_CAP;
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_q || m_axis_tready) begin
          mode_d      = fin_mode;
          ptime_d     = fin_ptime;
          tripped_d   = tripped_q | fin_trip;
          out_valid_d = 1'b1;
          out_data_d  = {2'd0, delay_q, ~(tripped_q | fin_trip), fin_ev, fin_mode};
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mode_q      <= MODE_SETTLING;
      ptime_q     <= '0;
      deadline_q  <= '0;
      tripped_q   <= 1'b0;
      delay_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      ptime_q     <= ptime_d;
      deadline_q  <= deadline_d;
      tripped_q   <= tripped_d;
      delay_q     <= delay_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m1_q       <= m1_d;
    need_q     <= need_d;
    ratio_q    <= ratio_d;
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule
